@@ sv/rfmw_pkg.sv @@
// ----------------------------------------------------------------------------
// rfmw_pkg
// Shared widths and register indexes for the rotate forward map writer.
// ----------------------------------------------------------------------------
package rfmw_pkg;

    localparam int WORD_W      = 32;
    localparam int ADDR_W      = 20;
    localparam int SIZE_W      = 11;
    localparam int COEF_W      = 16;
    localparam int FRAC_W      = 14;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(320);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
    localparam logic [COEF_W-1:0] COS_RESET    = COEF_W'(16384);
    localparam logic [COEF_W-1:0] SIN_RESET    = COEF_W'(0);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH_UNITS,
        CFG_FRAME_HEIGHT,
        CFG_COS_COEF,
        CFG_SIN_COEF
    } cfg_index_t;

endpackage

@@ sv/rfmw_if.sv @@
// ----------------------------------------------------------------------------
// rfmw_if
// Valid/ready channels: source pixel words in, destination writes out.
// ----------------------------------------------------------------------------
interface rfmw_pixel_if import rfmw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pixel_word;
    logic              frame_start;

    modport source (output valid, output pixel_word, output frame_start, input ready);
    modport sink (input valid, input pixel_word, input frame_start, output ready);
endinterface

interface rfmw_write_if import rfmw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] dest_address;
    logic [WORD_W-1:0] dest_word;

    modport source (output valid, output dest_address, output dest_word, input ready);
    modport sink (input valid, input dest_address, input dest_word, output ready);
endinterface

@@ sv/rotate_forward_map_writer.sv @@
// ----------------------------------------------------------------------------
// rotate_forward_map_writer
// Rotates raster source positions about the image center with Q1.14
// coefficients and emits a destination write for targets inside the image.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-----------------------------------
//   pixel    | in  | valid / ready  | pixel_word, frame_start
//   write    | out | valid / ready  | dest_address, dest_word
//   cfg      | in  | cfg_we         | cfg_index, cfg_data
//
// one word per clock while the write channel takes its writes; each word
// passes the input, product, sum, bounds and address stages in turn
// every stage advances into a free slot, so ready drops only when all five
// stages hold words and the write channel stalls
// reset clears the counters and stage valids and loads the default registers
// ----------------------------------------------------------------------------
module rotate_forward_map_writer import rfmw_pkg::*; #(
    parameter int MAX_WIDTH_UNITS = 1024,
    parameter int MAX_HEIGHT      = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rfmw_pixel_if.sink             pixel,
    rfmw_write_if.source           write,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int WUW = $clog2(MAX_WIDTH_UNITS + 1);
    localparam int HUW = $clog2(MAX_HEIGHT + 1);
    localparam int CCW = $clog2(MAX_WIDTH_UNITS);
    localparam int RCW = $clog2(MAX_HEIGHT);
    localparam int DXW = CCW + 2;
    localparam int DYW = RCW + 2;
    localparam int PXW = COEF_W + DXW;
    localparam int PYW = COEF_W + DYW;
    localparam int SW  = ((PXW > PYW) ? PXW : PYW) + 2;
    localparam int QW  = SW - FRAC_W;
    localparam int EWW = (SIZE_W > WUW) ? SIZE_W : WUW;
    localparam int EHW = (SIZE_W > HUW) ? SIZE_W : HUW;
    localparam int AW  = (RCW + WUW + 1 > ADDR_W) ? RCW + WUW + 1 : ADDR_W;

    localparam logic [EWW-1:0] MAX_W_E = EWW'(MAX_WIDTH_UNITS);
    localparam logic [EHW-1:0] MAX_H_E = EHW'(MAX_HEIGHT);

    // configuration registers
    logic        [SIZE_W-1:0] width_units_reg;
    logic        [SIZE_W-1:0] frame_height_reg;
    logic signed [COEF_W-1:0] cos_coef_reg;
    logic signed [COEF_W-1:0] sin_coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_units_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            cos_coef_reg     <= COS_RESET;
            sin_coef_reg     <= SIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WIDTH_UNITS:  width_units_reg  <= cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_COS_COEF:     cos_coef_reg     <= cfg_data[COEF_W-1:0];
                CFG_SIN_COEF:     sin_coef_reg     <= cfg_data[COEF_W-1:0];
            endcase
        end
    end

    // clamped frame size and center
    logic [EWW-1:0] w_ext;
    logic [EHW-1:0] h_ext;
    logic [WUW-1:0] w_eff;
    logic [HUW-1:0] h_eff;
    logic [WUW-2:0] x0;
    logic [HUW-2:0] y0;

    always_comb
    begin
        w_ext = EWW'(width_units_reg);
        h_ext = EHW'(frame_height_reg);
        priority if (w_ext == '0)
            w_eff = WUW'(1);
        else if (w_ext > MAX_W_E)
            w_eff = WUW'(MAX_WIDTH_UNITS);
        else
            w_eff = w_ext[WUW-1:0];
        priority if (h_ext == '0)
            h_eff = HUW'(1);
        else if (h_ext > MAX_H_E)
            h_eff = HUW'(MAX_HEIGHT);
        else
            h_eff = h_ext[HUW-1:0];
        x0 = w_eff[WUW-1:1];
        y0 = h_eff[HUW-1:1];
    end

    // stage valids and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic r1, r2, r3, r4, r5;
    logic in_fire;
    logic in_bounds;

    assign r5      = !out_v_reg || write.ready;
    assign r4      = !v4_reg || r5;
    assign r3      = !v3_reg || r4;
    assign r2      = !v2_reg || r3;
    assign r1      = !v1_reg || r2;
    assign in_fire = pixel.valid && r1;
    assign pixel.ready = r1;

    // position counters
    logic [CCW-1:0] col_reg, col_next, base_col;
    logic [RCW-1:0] row_reg, row_next, base_row;
    logic [WUW-1:0] col_inc;
    logic [HUW-1:0] row_inc;

    always_comb
    begin
        base_col = pixel.frame_start ? '0 : col_reg;
        base_row = pixel.frame_start ? '0 : row_reg;
        col_inc  = WUW'(base_col) + WUW'(1);
        row_inc  = HUW'(base_row) + HUW'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[RCW-1:0];
        end
        else
        begin
            col_next = col_inc[CCW-1:0];
            row_next = base_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // datapath
    logic signed [DXW-1:0] dx_next, dx_reg;
    logic signed [DYW-1:0] dy_next, dy_reg;
    logic [WORD_W-1:0]     word1_reg, word2_reg, word3_reg, word4_reg, word5_reg;
    logic signed [PXW-1:0] p_cx_reg, p_sx_reg;
    logic signed [PYW-1:0] p_sy_reg, p_cy_reg;
    logic signed [SW-1:0]  nx_next, ny_next, nx_reg, ny_reg;
    logic signed [QW-1:0]  qx, qy;
    logic [CCW-1:0]        x2_reg;
    logic [RCW-1:0]        y2_reg;
    logic [AW-1:0]         addr_full;
    logic [ADDR_W-1:0]     addr_reg;

    assign dx_next = $signed(DXW'(base_col)) - $signed(DXW'(x0));
    assign dy_next = $signed(DYW'(base_row)) - $signed(DYW'(y0));

    assign nx_next = SW'(p_cx_reg) - SW'(p_sy_reg) + $signed(SW'(x0) << FRAC_W);
    assign ny_next = SW'(p_sx_reg) + SW'(p_cy_reg) + $signed(SW'(y0) << FRAC_W);

    // round toward zero: floor, then step up for negative values with a fraction
    assign qx = $signed(nx_reg[SW-1:FRAC_W])
              + $signed(QW'(nx_reg[SW-1] && (nx_reg[FRAC_W-1:0] != '0)));
    assign qy = $signed(ny_reg[SW-1:FRAC_W])
              + $signed(QW'(ny_reg[SW-1] && (ny_reg[FRAC_W-1:0] != '0)));

    assign in_bounds = !qx[QW-1] && !qy[QW-1]
                    && (qx[QW-2:0] < (QW-1)'(w_eff))
                    && (qy[QW-2:0] < (QW-1)'(h_eff));

    assign addr_full = AW'(y2_reg) * AW'(w_eff) + AW'(x2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= pixel.valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg && in_bounds;
            if (r5)
                out_v_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            word1_reg <= pixel.pixel_word;
        end
        if (r2)
        begin
            p_cx_reg  <= cos_coef_reg * dx_reg;
            p_sx_reg  <= sin_coef_reg * dx_reg;
            p_sy_reg  <= sin_coef_reg * dy_reg;
            p_cy_reg  <= cos_coef_reg * dy_reg;
            word2_reg <= word1_reg;
        end
        if (r3)
        begin
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            word3_reg <= word2_reg;
        end
        if (r4)
        begin
            x2_reg    <= qx[CCW-1:0];
            y2_reg    <= qy[RCW-1:0];
            word4_reg <= word3_reg;
        end
        if (r5)
        begin
            addr_reg  <= addr_full[ADDR_W-1:0];
            word5_reg <= word4_reg;
        end
    end

    assign write.valid        = out_v_reg;
    assign write.dest_address = addr_reg;
    assign write.dest_word    = word5_reg;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_v_reg))
        else $error("input stalled with a free stage");

    a_frame_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pixel.frame_start) |=> (col_reg <= CCW'(1) && row_reg <= RCW'(1)))
        else $error("counters not near origin after frame start");

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && r2) |=> v2_reg)
        else $error("word lost between input and product stage");

endmodule

@@ sim/tb_rotate_forward_map_writer.sv @@
// ----------------------------------------------------------------------------
// tb_rotate_forward_map_writer
// Self-checking bench for the rotate forward map writer. A behavioral
// predictor rotates each accepted source position about the image center and
// queues the destination write it should cause; every write taken from the
// block is compared field by field with the oldest queued one. Directed cases
// cover the reset settings, far corners, size clamping, coefficient extremes
// and a mid-frame size change. Random register settings and pixel words then
// run under three back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_rotate_forward_map_writer import rfmw_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 1024;
    localparam int DRAIN_TAIL  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
    } dest_write_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rfmw_pixel_if pixel_ch ();
    rfmw_write_if write_ch ();

    rotate_forward_map_writer #(
        .MAX_WIDTH_UNITS (MAX_W),
        .MAX_HEIGHT      (MAX_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .write     (write_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [SIZE_W-1:0]        width_units_r  = WIDTH_RESET;
    logic [SIZE_W-1:0]        frame_height_r = HEIGHT_RESET;
    logic signed [COEF_W-1:0] cos_r          = COEF_W'(16384);
    logic signed [COEF_W-1:0] sin_r          = '0;
    int                       col_pos        = 0;
    int                       row_pos        = 0;

    dest_write_t expected_writes[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int error_count     = 0;
    int words_sent      = 0;
    int writes_checked  = 0;
    int settings_loaded = 0;
    int cycle_count     = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic bit rotate_position(input logic start, output logic [ADDR_W-1:0] addr);
        longint w, h, x0, y0, dx, dy, nx, ny, x2, y2;
        bit     hit;
        w = (width_units_r == 0) ? 1 : ((width_units_r > MAX_W) ? MAX_W : width_units_r);
        h = (frame_height_r == 0) ? 1 : ((frame_height_r > MAX_H) ? MAX_H : frame_height_r);
        if (start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x0 = w >>> 1;
        y0 = h >>> 1;
        dx = longint'(col_pos) - x0;
        dy = longint'(row_pos) - y0;
        nx = longint'(cos_r) * dx - longint'(sin_r) * dy + x0 * 16384;
        ny = longint'(sin_r) * dx + longint'(cos_r) * dy + y0 * 16384;
        x2 = nx / 16384;
        y2 = ny / 16384;
        hit = (x2 >= 0) && (y2 >= 0) && (x2 < w) && (y2 < h);
        addr = ADDR_W'(y2 * w + x2);
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
        end
        return hit;
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        write_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // write checker
    always @(posedge clk)
    begin
        dest_write_t want;
        if (rst_n && write_ch.valid && write_ch.ready)
        begin
            if (expected_writes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected write addr %05h word %08h",
                                          write_ch.dest_address, write_ch.dest_word));
            end
            else
            begin
                want = expected_writes.pop_front();
                writes_checked++;
                if (write_ch.dest_address !== want.addr)
                begin
                    report_mismatch($sformatf("dest_address %05h, expected %05h",
                                              write_ch.dest_address, want.addr));
                end
                if (write_ch.dest_word !== want.word)
                begin
                    report_mismatch($sformatf("dest_word %08h, expected %08h",
                                              write_ch.dest_word, want.word));
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_pixel(input logic [WORD_W-1:0] word, input logic start);
        logic [ADDR_W-1:0] addr;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid       <= 1'b1;
        pixel_ch.pixel_word  <= word;
        pixel_ch.frame_start <= start;
        @(posedge clk);
        while (!pixel_ch.ready)
        begin
            @(posedge clk);
        end
        if (rotate_position(start, addr))
        begin
            expected_writes.push_back('{addr: addr, word: word});
        end
        words_sent++;
    endtask

    // hold the sender until every pending write has come out
    task automatic wait_drained();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic load_config(input int w, input int h, input int c, input int s);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH_UNITS;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= CFG_COS_COEF;
        cfg_data  <= CFG_DATA_W'(c);
        @(posedge clk);
        cfg_index <= CFG_SIN_COEF;
        cfg_data  <= CFG_DATA_W'(s);
        @(posedge clk);
        cfg_we <= 1'b0;
        width_units_r  = SIZE_W'(w);
        frame_height_r = SIZE_W'(h);
        cos_r          = COEF_W'(c);
        sin_r          = COEF_W'(s);
        settings_loaded++;
    endtask

    task automatic test_reset_settings();
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hA5A5_5A5A, 1'b0);
        wait_drained();
    endtask

    // quarter turn at full size: first word lands off the bottom, the rest near it
    task automatic test_far_corner();
        load_config(MAX_W, MAX_H, 0, -16384);
        send_pixel(32'hFFFF_FFFF, 1'b1);
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'h1234_5678, 1'b0);
        send_pixel(32'hFEDC_BA98, 1'b0);
        wait_drained();
    endtask

    task automatic test_size_clamp();
        load_config(0, 0, 16384, 0);
        send_pixel($urandom, 1'b1);
        send_pixel($urandom, 1'b0);
        wait_drained();
        load_config(2047, 2047, -16384, 0);
        send_pixel($urandom, 1'b1);
        send_pixel($urandom, 1'b0);
        wait_drained();
    endtask

    task automatic test_coef_extremes();
        load_config(16, 16, 32767, -32768);
        send_pixel($urandom, 1'b1);
        send_pixel($urandom, 1'b0);
        send_pixel($urandom, 1'b0);
        wait_drained();
    endtask

    task automatic test_shrink_midframe();
        load_config(8, 8, 16384, 0);
        send_pixel($urandom, 1'b1);
        repeat (5) send_pixel($urandom, 1'b0);
        wait_drained();
        load_config(3, 1, 16384, 0);
        send_pixel($urandom, 1'b0);
        send_pixel($urandom, 1'b0);
        wait_drained();
    endtask

    function automatic int pick_size();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            return $urandom_range(1, 24);
        end
        else if (sel == 7)
        begin
            return 0;
        end
        else if (sel == 8)
        begin
            return $urandom_range(1025, 2047);
        end
        return $urandom_range(25, 1024);
    endfunction

    task automatic test_random(input int sender_pct, input int receiver_pct, input int n_words);
        int w, h, c, s, seg_len, sent;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        sent = 0;
        while (sent < n_words)
        begin
            w = pick_size();
            h = pick_size();
            case ($urandom_range(0, 5))
                0: begin c = 16384;  s = 0;      end
                1: begin c = 0;      s = 16384;  end
                2: begin c = -16384; s = 0;      end
                3: begin c = 0;      s = -16384; end
                4:
                begin
                    c = $urandom_range(0, 32768) - 16384;
                    s = $urandom_range(0, 32768) - 16384;
                end
                default: begin c = $urandom_range(0, 65535); s = $urandom_range(0, 65535); end
            endcase
            load_config(w, h, c, s);
            seg_len = $urandom_range(10, 50);
            for (int i = 0; i < seg_len; i++)
            begin
                send_pixel($urandom,
                           (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 4));
                sent++;
            end
            wait_drained();
        end
    endtask

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        pixel_ch.valid       = 1'b0;
        pixel_ch.pixel_word  = '0;
        pixel_ch.frame_start = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_far_corner();
        test_size_clamp();
        test_coef_extremes();
        test_shrink_midframe();
        test_random(27, 88, 170);
        test_random(88, 27, 170);
        test_random(0, 0, 160);

        if (expected_writes.size() != 0)
        begin
            report_mismatch($sformatf("%0d writes never arrived", expected_writes.size()));
        end
        $display("sent %0d pixel words over %0d register settings, checked %0d writes",
                 words_sent, settings_loaded, writes_checked);
        $display("mismatches counted: %0d", error_count);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
